// ===== sv/assert_macros.svh =====
// Assertion macros used by the resampler top level.
// No dependencies; take in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, disabled while reset is held.
`define IQD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising edge, reset cycles included.
`define IQD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/iqd_pkg.sv =====
// Shared types and constants for the I/Q linear interpolation downsampler.
// No dependencies; imported by every module of the block.
package iqd_pkg;

  localparam int SAMPLE_W        = 16;
  localparam int RATIO_W         = 24;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_i;
    logic signed [SAMPLE_W-1:0] sample_q;
  } iq_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_i;
    logic signed [SAMPLE_W-1:0] out_q;
  } iq_out_t;

  // Both end points of one interpolation
  typedef struct packed {
    iq_in_t prev;
    iq_in_t cur;
  } iq_pair_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== sv/iqd_front.sv =====
// Front end: accepts input beats, tracks phase and previous sample, queues outputs due.
// Depends on iqd_pkg.
module iqd_front #(
  parameter int FRAC_BITS = iqd_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  iqd_pkg::iq_in_t             in_data,
  input  logic                        cfg_we,
  input  logic [iqd_pkg::RATIO_W-1:0] cfg_data,
  input  iqd_pkg::q_stat_t            q_stat,
  output logic                        q_push,
  output iqd_pkg::iq_pair_t           q_pair,
  output logic [FRAC_BITS-1:0]        q_weight
);
  import iqd_pkg::*;

  localparam int PH_W  = FRAC_BITS + 9;
  localparam int ACC_W = ((PH_W > RATIO_W + 1) ? PH_W : RATIO_W + 1) + 1;
  localparam logic [ACC_W-1:0]   ONE_A     = ACC_W'(1) << FRAC_BITS;
  localparam logic [RATIO_W-1:0] RATIO_RST = ONE_A[RATIO_W-1:0];

  logic [RATIO_W-1:0] ratio_r, ratio_nxt;
  logic [PH_W-1:0]    phase_r, phase_nxt;
  iq_in_t             prev_r, prev_nxt;

  logic             accept;
  logic             emit;
  logic [ACC_W-1:0] ratio_ext, ratio_eff, phase_ext, phase_sum;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    ratio_ext = ACC_W'(ratio_r);
    // clamp ratios below one up to exactly one
    ratio_eff = (ratio_ext < ONE_A) ? ONE_A : ratio_ext;
    phase_ext = ACC_W'(phase_r);
    emit      = phase_ext < ONE_A;
    phase_sum = emit ? (phase_ext + ratio_eff - ONE_A) : (phase_ext - ONE_A);
    phase_nxt = accept ? phase_sum[PH_W-1:0] : phase_r;
    prev_nxt  = accept ? in_data : prev_r;
    ratio_nxt = cfg_we ? cfg_data : ratio_r;
  end

  assign q_push   = accept && emit;
  assign q_pair   = '{prev: prev_r, cur: in_data};
  assign q_weight = phase_r[FRAC_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_r <= RATIO_RST;
      phase_r <= '0;
      prev_r  <= '0;
    end else begin
      ratio_r <= ratio_nxt;
      phase_r <= phase_nxt;
      prev_r  <= prev_nxt;
    end
  end

endmodule

// ===== sv/iqd_queue.sv =====
// Short queue of pending interpolations between front and back end.
// Depends on iqd_pkg.
module iqd_queue #(
  parameter int DEPTH  = iqd_pkg::QUEUE_DEPTH_DEF,
  parameter int W_BITS = iqd_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  iqd_pkg::iq_pair_t push_pair,
  input  logic [W_BITS-1:0] push_weight,
  input  logic              pop,
  output iqd_pkg::iq_pair_t pop_pair,
  output logic [W_BITS-1:0] pop_weight,
  output iqd_pkg::q_stat_t  stat
);
  import iqd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  iq_pair_t          pair_mem [DEPTH];
  logic [W_BITS-1:0] weight_mem [DEPTH];

  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + CNT_W'(1);
      2'b01:   count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      pair_mem[wr_ptr_r]   <= push_pair;
      weight_mem[wr_ptr_r] <= push_weight;
    end
  end

  assign pop_pair   = pair_mem[rd_ptr_r];
  assign pop_weight = weight_mem[rd_ptr_r];
  assign stat.full  = count_r == CNT_W'(DEPTH);
  assign stat.empty = count_r == '0;

endmodule

// ===== sv/iqd_back.sv =====
// Back end: three-stage interpolation pipeline (multiply, sum, truncate), the last stage being the output register.
// Depends on iqd_pkg.
module iqd_back #(
  parameter int FRAC_BITS = iqd_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  iqd_pkg::q_stat_t     q_stat,
  input  iqd_pkg::iq_pair_t    q_pair,
  input  logic [FRAC_BITS-1:0] q_weight,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output iqd_pkg::iq_out_t     out_data
);
  import iqd_pkg::*;

  localparam int PROD_W = SAMPLE_W + FRAC_BITS + 2;
  localparam int SUM_W  = PROD_W + 1;
  localparam logic [FRAC_BITS:0] ONE_W = {1'b1, {FRAC_BITS{1'b0}}};

  function automatic logic signed [PROD_W-1:0] widen(input logic signed [SAMPLE_W-1:0] v);
    return PROD_W'(v);
  endfunction

  // divide by 2^FRAC_BITS, truncating toward zero
  function automatic logic signed [SAMPLE_W-1:0] trunc_q(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] q;
    q = s >>> FRAC_BITS;
    if (s[SUM_W-1] && (s[FRAC_BITS-1:0] != '0)) begin
      q = q + SUM_W'(1);
    end
    return q[SAMPLE_W-1:0];
  endfunction

  logic en;
  logic s1_valid_r, s2_valid_r, s3_valid_r;

  logic [FRAC_BITS:0]        w_lo, w_hi;
  logic signed [PROD_W-1:0]  w_lo_ext, w_hi_ext;
  logic signed [PROD_W-1:0]  pa_i_nxt, pb_i_nxt, pa_q_nxt, pb_q_nxt;
  logic signed [PROD_W-1:0]  pa_i_r, pb_i_r, pa_q_r, pb_q_r;
  logic signed [SUM_W-1:0]   sum_i_nxt, sum_q_nxt, sum_i_r, sum_q_r;
  iq_out_t                   out_nxt, out_r;

  // advance the whole pipe unless the output register holds an untaken beat
  assign en    = !s3_valid_r || out_ready;
  assign q_pop = en && !q_stat.empty;

  always_comb begin
    w_lo     = {1'b0, q_weight};
    w_hi     = ONE_W - w_lo;
    w_lo_ext = PROD_W'($signed({1'b0, w_lo}));
    w_hi_ext = PROD_W'($signed({1'b0, w_hi}));
    pa_i_nxt = widen(q_pair.prev.sample_i) * w_hi_ext;
    pb_i_nxt = widen(q_pair.cur.sample_i) * w_lo_ext;
    pa_q_nxt = widen(q_pair.prev.sample_q) * w_hi_ext;
    pb_q_nxt = widen(q_pair.cur.sample_q) * w_lo_ext;
    sum_i_nxt = SUM_W'(pa_i_r) + SUM_W'(pb_i_r);
    sum_q_nxt = SUM_W'(pa_q_r) + SUM_W'(pb_q_r);
    out_nxt.out_i = trunc_q(sum_i_r);
    out_nxt.out_q = trunc_q(sum_q_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= !q_stat.empty;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa_i_r  <= pa_i_nxt;
      pb_i_r  <= pb_i_nxt;
      pa_q_r  <= pa_q_nxt;
      pb_q_r  <= pb_q_nxt;
      sum_i_r <= sum_i_nxt;
      sum_q_r <= sum_q_nxt;
      out_r   <= out_nxt;
    end
  end

  assign out_valid = s3_valid_r;
  assign out_data  = out_r;

endmodule

// ===== sv/iq_linear_interp_downsampler.sv =====
// Top level of the I/Q linear interpolation downsampler; instantiates iqd_front,
// iqd_queue and iqd_back, uses iqd_pkg and assert_macros.svh.
//
// Input channel in_valid/in_ready/in_data carries one signed I/Q pair per beat.
// Output channel out_valid/out_ready/out_data carries interpolated pairs; an
// input beat yields one output beat or none, as the fractional phase dictates.
// cfg_we/cfg_data write the (RATIO_W-FRAC_BITS).FRAC_BITS ratio; write only
// while idle. Ratios below one act as exactly one.
// Throughput: one input beat per cycle, sustained, as long as the receiver
// takes output beats. After the edge that accepts an input beat, its output
// beat passes through the queue and the multiply, sum and truncate registers.
// The throughput figure is set by the front end's combinational phase update.
// Reset (rst_n low, synchronous) empties the queue and pipe, sets the ratio to
// one and clears the phase and the previous sample.
// When the receiver stalls, the output register holds its beat, the pipe
// freezes, and the queue absorbs up to QUEUE_DEPTH further outputs before
// in_ready drops.
`include "assert_macros.svh"

module iq_linear_interp_downsampler #(
  parameter int FRAC_BITS   = iqd_pkg::FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH = iqd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  iqd_pkg::iq_in_t             in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output iqd_pkg::iq_out_t            out_data,
  input  logic                        cfg_we,
  input  logic [iqd_pkg::RATIO_W-1:0] cfg_data
);
  import iqd_pkg::*;

  q_stat_t              q_stat;
  logic                 q_push, q_pop;
  iq_pair_t             push_pair, pop_pair;
  logic [FRAC_BITS-1:0] push_weight, pop_weight;

  // Front: hold the ratio, advance the phase, queue a beat when an output is due
  iqd_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_pair   (push_pair),
    .q_weight (push_weight)
  );

  // Queue: decouple the front's accept from the back's stall
  iqd_queue #(
    .DEPTH  (QUEUE_DEPTH),
    .W_BITS (FRAC_BITS)
  ) u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (q_push),
    .push_pair   (push_pair),
    .push_weight (push_weight),
    .pop         (q_pop),
    .pop_pair    (pop_pair),
    .pop_weight  (pop_weight),
    .stat        (q_stat)
  );

  // Back: mix previous and current samples, drive the output register
  iqd_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_pair    (pop_pair),
    .q_weight  (pop_weight),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Never push into a full queue, never pop an empty one
  `IQD_ASSERT(a_no_overflow, clk, rst_n, q_push |-> !q_stat.full, "queue overflow")
  `IQD_ASSERT(a_no_underflow, clk, rst_n, q_pop |-> !q_stat.empty, "queue underflow")
  // A stalled output register must freeze the pipe: no pop while it waits
  `IQD_ASSERT(a_stall_freeze, clk, rst_n, (out_valid && !out_ready) |-> !q_pop,
              "pop while output stalled")
  // No output beat straight after reset
  `IQD_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid, "output valid after reset")

endmodule

// ===== sim/iq_interp_checker.sv =====
// Checker for the I/Q linear interpolation downsampler: watches both channels
// and the ratio port, predicts each output beat and compares it field by field.
// Depends on iqd_pkg for the beat types and widths.
module iq_interp_checker
  import iqd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  iq_in_t              in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  iq_out_t             out_data,
  input  logic                cfg_we,
  input  logic [RATIO_W-1:0]  cfg_data,
  output int unsigned         errors,
  output int unsigned         pending_beats
);

  localparam int            FRAC    = FRAC_BITS_DEF;
  localparam int            PHASE_W = FRAC + 9;
  localparam logic [PHASE_W-1:0] UNIT = PHASE_W'(1) << FRAC;
  localparam longint        UNIT_L  = longint'(1) << FRAC;

  logic [RATIO_W-1:0]         ratio_reg;
  logic [PHASE_W-1:0]         phase_acc;
  logic signed [SAMPLE_W-1:0] last_i;
  logic signed [SAMPLE_W-1:0] last_q;
  iq_out_t                    interp_due[$];

  // prev * (1 - w) + cur * w, truncated toward zero
  function automatic logic signed [SAMPLE_W-1:0] blend(
    input logic signed [SAMPLE_W-1:0] a,
    input logic signed [SAMPLE_W-1:0] b,
    input logic [FRAC-1:0]            w
  );
    longint sum;
    longint quot;
    sum  = longint'(a) * (UNIT_L - longint'(w)) + longint'(b) * longint'(w);
    quot = sum / UNIT_L;
    return quot[SAMPLE_W-1:0];
  endfunction

  task automatic predict_beat(input iq_in_t d);
    logic [PHASE_W-1:0] step;
    iq_out_t            want;
    step = (ratio_reg < UNIT) ? UNIT : PHASE_W'(ratio_reg);
    if (phase_acc < UNIT) begin
      want.out_i = blend(last_i, d.sample_i, phase_acc[FRAC-1:0]);
      want.out_q = blend(last_q, d.sample_q, phase_acc[FRAC-1:0]);
      interp_due.push_back(want);
      phase_acc = PHASE_W'(phase_acc + step - UNIT);
    end else begin
      phase_acc = PHASE_W'(phase_acc - UNIT);
    end
    last_i = d.sample_i;
    last_q = d.sample_q;
  endtask

  task automatic compare_beat(input iq_out_t got);
    iq_out_t want;
    if (interp_due.size() == 0) begin
      $display("%0t: unexpected output beat, got i=%0d q=%0d",
               $time, got.out_i, got.out_q);
      errors++;
    end else begin
      want = interp_due.pop_front();
      if (got.out_i !== want.out_i) begin
        $display("%0t: out_i mismatch, expected %0d got %0d",
                 $time, want.out_i, got.out_i);
        errors++;
      end
      if (got.out_q !== want.out_q) begin
        $display("%0t: out_q mismatch, expected %0d got %0d",
                 $time, want.out_q, got.out_q);
        errors++;
      end
    end
  endtask

  initial begin
    errors        = 0;
    pending_beats = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      ratio_reg = RATIO_W'(UNIT);
      phase_acc = '0;
      last_i    = '0;
      last_q    = '0;
      interp_due.delete();
    end else begin
      if (out_valid && out_ready) compare_beat(out_data);
      if (cfg_we) ratio_reg = cfg_data;
      if (in_valid && in_ready) predict_beat(in_data);
    end
    pending_beats = interp_due.size();
  end

endmodule

// ===== sim/testbench.sv =====
// Top of the downsampler test: clock, reset, ratio writes and I/Q stimulus,
// with random idling on both channels. Depends on iqd_pkg, the block
// iq_linear_interp_downsampler and the checker iq_interp_checker.
module testbench;
  import iqd_pkg::*;

  localparam int          FRAC        = FRAC_BITS_DEF;
  localparam logic [RATIO_W-1:0] ONE_R = RATIO_W'(1) << FRAC;
  localparam int          SETTLE      = 10;     // pipe latency plus margin
  localparam int          LONG_HOLD   = 40;     // receiver hold-off, cycles
  localparam int unsigned CYCLE_LIMIT = 100000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  iq_in_t             in_data;
  logic               out_valid;
  logic               out_ready;
  iq_out_t            out_data;
  logic               cfg_we;
  logic [RATIO_W-1:0] cfg_data;

  int unsigned errors;
  int unsigned pending_beats;
  int unsigned cycle_count;
  logic        calm;        // no idling on either side
  logic        hold_long;   // ask the receiver for one long hold-off

  iq_linear_interp_downsampler u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  iq_interp_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .errors        (errors),
    .pending_beats (pending_beats)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort the run if it hangs; a correct run ends far below this.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // Receiver: each pass sets out_ready once and then waits on falling edges,
  // so out_ready never sees two assignments in one step.
  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_long) begin
        // Hold off long enough for the queue to fill and in_ready to drop
        hold_long = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // Bias sample values toward the extremes and values round zero, where
  // truncation toward zero differs from flooring.
  function automatic logic [SAMPLE_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return SAMPLE_W'(int'($urandom_range(0, 8)) - 4);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [RATIO_W-1:0] pick_ratio();
    case ($urandom_range(0, 4))
      0:       return ONE_R;
      1:       return RATIO_W'($urandom_range(0, ONE_R - 1));            // acts as one
      2:       return RATIO_W'($urandom_range(ONE_R + 1, ONE_R + 255));  // slow drift of w
      3:       return RATIO_W'($urandom_range(ONE_R, 2 * ONE_R - 1));
      default: return RATIO_W'($urandom_range(2 * ONE_R, 6 * ONE_R));
    endcase
  endfunction

  // Offer one beat, starting and ending on a falling edge. A random gap may
  // precede it unless the run is in its calm part.
  task automatic send_sample(input logic [SAMPLE_W-1:0] si,
                             input logic [SAMPLE_W-1:0] sq);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_data.sample_i <= si;
    in_data.sample_q <= sq;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random(input int count);
    repeat (count) send_sample(pick_value(), pick_value());
  endtask

  // Drop valid and wait until every predicted beat has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_beats != 0) @(negedge clk);
  endtask

  // Write the ratio only once the block is idle: wait until every predicted
  // beat has come out, then let the pipe latency pass as a margin.
  task automatic write_ratio(input logic [RATIO_W-1:0] value);
    drain_results();
    repeat (SETTLE) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_data  = '0;
    calm      = 1'b0;
    hold_long = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset ratio is one: the first beat gives the cleared previous sample,
    // then each output repeats the sample before, w staying at zero.
    send_sample(16'h7FFF, 16'h8000);
    send_sample(16'h8000, 16'h7FFF);
    send_sample(16'h0000, 16'hFFFF);
    send_sample(16'hFFFF, 16'h0000);
    send_sample(16'h7FFF, 16'h7FFF);
    send_sample(16'h8000, 16'h8000);

    // Ratio one and a half: w alternates between zero and one half, so
    // opposite extremes and -1/0 pairs land on -0.5, which must truncate to 0.
    write_ratio(ONE_R + (ONE_R >> 1));
    send_sample(16'h7FFF, 16'h8000);
    send_sample(16'h8000, 16'h7FFF);
    send_sample(16'h7FFF, 16'h8000);
    send_sample(16'hFFFF, 16'h0002);
    send_sample(16'h0000, 16'hFFFD);
    send_sample(16'hFFFF, 16'h0001);
    send_sample(16'h0001, 16'hFFFF);
    send_sample(16'h8000, 16'h7FFF);

    // Ratios below one, zero included, act as exactly one
    write_ratio('0);
    send_random(3);
    write_ratio(ONE_R - 1);
    send_random(2);

    // Largest ratio: one output, then some 255 beats with none, which runs
    // the phase to just under 255 and counts it back down.
    write_ratio({RATIO_W{1'b1}});
    send_random(270);
    write_ratio(RATIO_W'($urandom_range(ONE_R, 2 * ONE_R)));
    send_random(40);

    for (int p = 0; p < 6; p++) begin
      if (p == 1) begin
        // Dense outputs while the receiver holds off fills the block
        write_ratio(ONE_R);
        hold_long = 1'b1;
        send_random(45);
      end else if (p == 2) begin
        // Pause the sender mid-phase until every output is out
        write_ratio(pick_ratio());
        send_random(20);
        drain_results();
        send_random(25);
      end else begin
        write_ratio(pick_ratio());
        send_random(25);
      end
    end

    // Calm tail: both sides run flat out
    write_ratio(RATIO_W'($urandom_range(ONE_R, 3 * ONE_R)));
    calm = 1'b1;
    send_random(40);

    drain_results();
    repeat (SETTLE) @(negedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
